// ===== hw/rtl/b2da_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
   localparam int TEXT_W     = 64;
   localparam int LEN_W      = 4;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 3;
   localparam int CNT_W      = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;

   // Double-dabble correction of one BCD digit before the next left shift.
   function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      r = (d >= 4'd5) ? d + 4'd3 : d;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/b2da_dabble.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_dabble
// Bit-serial shift-and-add-3 converter, one value bit per cycle. Only the low
// MAX_DIGITS decimal digits are kept, which yields the value modulo 10^8.
// ----------------------------------------------------------------------------
module b2da_dabble (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
   output logic                               done,
   output logic      [b2da_pkg::BCD_W-1:0]    bcd
);

   logic [b2da_pkg::VALUE_W-1:0] bin_ff;
   logic [b2da_pkg::BCD_W-1:0]   bcd_ff;
   logic [b2da_pkg::BCD_W-1:0]   adj_in;
   logic [b2da_pkg::CNT_W-1:0]   cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;

   // digits are independent; carries out of a digit only travel with the shift
   always_comb begin
      for (int k = 0; k < b2da_pkg::MAX_DIGITS; k++) begin
         adj_in[k*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
            b2da_pkg::add3(bcd_ff[k*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            bin_ff  <= value;
            bcd_ff  <= '0;
         end else if (busy_ff) begin
            bcd_ff <= {adj_in[b2da_pkg::BCD_W-2:0], bin_ff[b2da_pkg::VALUE_W-1]};
            bin_ff <= {bin_ff[b2da_pkg::VALUE_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == b2da_pkg::CNT_W'(b2da_pkg::VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 32-bit unsigned value to right-justified decimal ASCII text of
// 0 to 8 characters with leading zeros shown as spaces.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries req_value and
//   req_digit_count. Counts above 8 are clamped to 8. One response per
//   request on rsp_valid/rsp_stall: rsp_text holds the leftmost character
//   in bits 7:0, unused bytes zero, and rsp_text_length the clamped count.
//   From request accept to rsp_valid the block runs bit-serial shift-add-3
//   conversion over the value bits, a handoff, emission of one character
//   per cycle for the clamped count, and a load of the response register.
//   One request is in flight at a time: a new request is taken only once
//   the previous one has been loaded into the response register.
//   The response register is separate from the converter, so a new request
//   is taken while a finished response is still stalled; the converted text
//   then waits until the response register frees up.
//   Synchronous active-high reset empties the response register and returns
//   the block to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [b2da_pkg::VALUE_W-1:0]    req_value,
   input  wire logic [b2da_pkg::LEN_W-1:0]      req_digit_count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [b2da_pkg::TEXT_W-1:0]     rsp_text,
   output logic      [b2da_pkg::LEN_W-1:0]      rsp_text_length
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_FMT,
      S_DONE
   } state_type;

   state_type                      state_ff;
   logic [b2da_pkg::LEN_W-1:0]     len_ff;
   logic [b2da_pkg::IDX_W-1:0]     idx_ff;
   logic                           lead_ff;
   logic [b2da_pkg::TEXT_W-1:0]    text_ff;
   logic                           rsp_valid_ff;
   logic [b2da_pkg::TEXT_W-1:0]    rsp_text_ff;
   logic [b2da_pkg::LEN_W-1:0]     rsp_len_ff;

   logic                           req_accept;
   logic                           conv_done;
   logic [b2da_pkg::BCD_W-1:0]     conv_bcd;
   logic [b2da_pkg::LEN_W-1:0]     len_in;
   logic [b2da_pkg::IDX_W-1:0]     last_idx;
   logic [b2da_pkg::IDX_W-1:0]     dig_idx;
   logic [b2da_pkg::DIGIT_W-1:0]   dig;
   logic                           is_last;
   logic                           blank;
   logic [b2da_pkg::CHAR_W-1:0]    fmt_char;
   logic                           rsp_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign len_in = (req_digit_count > b2da_pkg::LEN_W'(b2da_pkg::MAX_DIGITS)) ?
                   b2da_pkg::LEN_W'(b2da_pkg::MAX_DIGITS) : req_digit_count;

   b2da_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .value (req_value),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   // characters go out most significant digit first
   assign last_idx = b2da_pkg::IDX_W'(len_ff - 1'b1);
   assign dig_idx  = last_idx - idx_ff;
   assign dig      = conv_bcd[dig_idx*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
   assign is_last  = (idx_ff == last_idx);
   assign blank    = lead_ff && !is_last && (dig == '0);
   assign fmt_char = blank ? b2da_pkg::BLANK_CHAR :
                     (b2da_pkg::ZERO_CHAR | b2da_pkg::CHAR_W'(dig));

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_DONE handles the response register itself when it reloads
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  len_ff   <= len_in;
                  state_ff <= S_CONV;
               end
            end
            S_CONV: begin
               if (conv_done) begin
                  text_ff <= '0;
                  idx_ff  <= '0;
                  lead_ff <= 1'b1;
                  state_ff <= (len_ff == '0) ? S_DONE : S_FMT;
               end
            end
            S_FMT: begin
               text_ff[{idx_ff, 3'b000} +: b2da_pkg::CHAR_W] <= fmt_char;
               if (!blank) begin
                  lead_ff <= 1'b0;
               end
               if (is_last) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_text_ff  <= text_ff;
                  rsp_len_ff   <= len_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text        = rsp_text_ff;
   assign rsp_text_length = rsp_len_ff;

`ifndef SYNTH
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_text_length <= b2da_pkg::LEN_W'(b2da_pkg::MAX_DIGITS))
      else $error("response length above maximum");

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> state_ff == S_CONV)
      else $error("conversion finished outside conversion phase");

   a_fmt_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FMT |-> {1'b0, idx_ff} < len_ff)
      else $error("format index beyond text length");

   a_req_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_CONV)
      else $error("accepted request did not start conversion");
`endif

endmodule
`default_nettype wire
